@@ src/hduart_pkg.sv @@
`default_nettype none
package hduart_pkg;

	// fixed widths of the host-side fields
	localparam int WORD_W = 9;
	localparam int KIND_W = 2;

	// defaults for the top-level parameters
	localparam int TICKS_PER_BIT_DEF = 3;
	localparam int DATA_BITS_DEF     = 9;

	// input item kinds
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	// one result item
	typedef struct packed {
		logic              line_drive_low;
		logic [WORD_W-1:0] read_word;
		logic              read_valid;
		logic              write_accepted;
		logic              tx_pending;
		logic              rx_full;
	} hduart_res_t;

endpackage
`default_nettype wire

@@ src/half_duplex_nine_bit_soft_uart_unit.sv @@
// channel | handshake           | payload
// --------+---------------------+-----------------------------------------------
// in      | in_valid / in_stall | kind, line_level, write_word
// out     | out_valid/out_stall | line_drive_low, read_word, read_valid,
//         |                     | write_accepted, tx_pending, rx_full
//
// one item per cycle while in_stall is low: the frame state updates at the
// input transfer and the result is registered in the output or skid register.
// a skid register behind the output register takes one more item while the
// output is stalled; in_stall rises only while the skid register is full.
// arst_n clears the frame state, both full flags and the output valids;
// the receive and transmit buffers hold no reset value.
`default_nettype none
module half_duplex_nine_bit_soft_uart_unit
	import hduart_pkg::*;
#(
	parameter int TICKS_PER_BIT = TICKS_PER_BIT_DEF,
	parameter int DATA_BITS     = DATA_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic              line_level,
	input  wire logic [WORD_W-1:0] write_word,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   line_drive_low,
	output logic [WORD_W-1:0]      read_word,
	output logic                   read_valid,
	output logic                   write_accepted,
	output logic                   tx_pending,
	output logic                   rx_full
);

	localparam int FRAME_BITS = DATA_BITS + 2;
	localparam int SH_W       = DATA_BITS + 2;
	localparam int TX_END     = FRAME_BITS * TICKS_PER_BIT;
	localparam int RX_FIRST   = TICKS_PER_BIT + TICKS_PER_BIT / 2;
	localparam int RX_STOP    = RX_FIRST + DATA_BITS * TICKS_PER_BIT;
	localparam int RX_SUB     = RX_FIRST % TICKS_PER_BIT;
	localparam int OFF_W      = $clog2(TX_END + 1);
	localparam int SUB_W      = $clog2(TICKS_PER_BIT);

	localparam logic [OFF_W-1:0] OFF_TX_END   = OFF_W'(TX_END);
	localparam logic [OFF_W-1:0] OFF_RX_FIRST = OFF_W'(RX_FIRST);
	localparam logic [OFF_W-1:0] OFF_RX_STOP  = OFF_W'(RX_STOP);
	localparam logic [SUB_W-1:0] SUB_LAST     = SUB_W'(TICKS_PER_BIT - 1);
	localparam logic [SUB_W-1:0] SUB_RX       = SUB_W'(RX_SUB);
	localparam logic [SUB_W-1:0] SUB_ONE      = SUB_W'(1);

	// frame state: offset counts ticks in the frame, sub tracks offset mod ticks-per-bit
	logic                 tx_mode_q;
	logic [OFF_W-1:0]     off_q;
	logic [SUB_W-1:0]     sub_q;
	logic [SH_W-1:0]      shifter_q;
	logic                 drive_low_q;
	logic                 tx_bit_q;
	logic [DATA_BITS-1:0] rx_buf_q;
	logic                 rx_full_q;
	logic [DATA_BITS-1:0] tx_buf_q;
	logic                 tx_full_q;

	logic                 tx_mode_nx;
	logic [OFF_W-1:0]     off_nx;
	logic [SUB_W-1:0]     sub_nx;
	logic [SH_W-1:0]      shifter_nx;
	logic                 drive_low_nx;
	logic                 tx_bit_nx;
	logic [DATA_BITS-1:0] rx_buf_nx;
	logic                 rx_full_nx;
	logic [DATA_BITS-1:0] tx_buf_nx;
	logic                 tx_full_nx;

	// output register and skid register
	hduart_res_t res_q;
	logic        res_valid_q;
	hduart_res_t skid_q;
	logic        skid_valid_q;
	hduart_res_t res_nx;

	logic accept;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;

	// next frame state and result for the item at the input
	always_comb begin
		logic [OFF_W-1:0] t_off;
		logic [SUB_W-1:0] t_sub;
		logic [SUB_W-1:0] sub_inc;
		logic [SH_W-1:0]  sh_v;
		logic             bit_v;
		tx_mode_nx   = tx_mode_q;
		off_nx       = off_q;
		sub_nx       = sub_q;
		shifter_nx   = shifter_q;
		drive_low_nx = drive_low_q;
		tx_bit_nx    = tx_bit_q;
		rx_buf_nx    = rx_buf_q;
		rx_full_nx   = rx_full_q;
		tx_buf_nx    = tx_buf_q;
		tx_full_nx   = tx_full_q;
		res_nx       = '0;
		t_off        = off_q;
		t_sub        = sub_q;
		sub_inc      = '0;
		sh_v         = shifter_q;
		bit_v        = tx_bit_q;

		unique case (kind)
			KIND_TICK: begin
				if (tx_mode_q) begin
					// transmit frame: wrap after the stop bit
					if (off_q >= OFF_TX_END) begin
						t_off = '0;
						t_sub = '0;
					end
					sub_inc = (t_sub == SUB_LAST) ? '0 : t_sub + SUB_ONE;
					if (t_off == '0 && !tx_full_q) begin
						// nothing pending: back to idle receive
						tx_mode_nx = 1'b0;
						off_nx     = '0;
						sub_nx     = '0;
					end else begin
						if (t_off == '0) begin
							sh_v       = {1'b1, tx_buf_q, 1'b0};
							tx_full_nx = 1'b0;
						end
						if (t_sub == '0) begin
							bit_v = sh_v[0];
							sh_v  = sh_v >> 1;
						end
						shifter_nx   = sh_v;
						tx_bit_nx    = bit_v;
						drive_low_nx = !bit_v;
						off_nx       = t_off + OFF_W'(1);
						sub_nx       = sub_inc;
					end
				end else begin
					sub_inc = (sub_q == SUB_LAST) ? '0 : sub_q + SUB_ONE;
					if (off_q == '0) begin
						// idle: pending transmit wins over a start bit
						if (tx_full_q) begin
							tx_mode_nx = 1'b1;
							off_nx     = '0;
							sub_nx     = '0;
						end else if (!line_level) begin
							shifter_nx = '0;
							off_nx     = OFF_W'(1);
							sub_nx     = SUB_ONE;
						end
					end else if (off_q >= OFF_RX_STOP) begin
						// end of receive frame, store only into an empty buffer
						if (!rx_full_q) begin
							rx_buf_nx  = shifter_q[DATA_BITS-1:0];
							rx_full_nx = 1'b1;
						end
						off_nx = '0;
						sub_nx = '0;
					end else begin
						// sample data bits mid-bit, lsb first
						if (off_q >= OFF_RX_FIRST && sub_q == SUB_RX) begin
							sh_v                = shifter_q >> 1;
							sh_v[DATA_BITS-1]   = sh_v[DATA_BITS-1] | line_level;
							shifter_nx          = sh_v;
						end
						off_nx = off_q + OFF_W'(1);
						sub_nx = sub_inc;
					end
				end
			end
			KIND_WRITE: begin
				if (!tx_full_q) begin
					tx_buf_nx             = write_word[DATA_BITS-1:0];
					tx_full_nx            = 1'b1;
					res_nx.write_accepted = 1'b1;
				end
			end
			KIND_READ: begin
				if (rx_full_q) begin
					res_nx.read_word  = WORD_W'(rx_buf_q);
					res_nx.read_valid = 1'b1;
					rx_full_nx        = 1'b0;
				end
			end
			default: begin
			end
		endcase

		res_nx.line_drive_low = drive_low_nx;
		res_nx.tx_pending     = tx_full_nx;
		res_nx.rx_full        = rx_full_nx;
	end

	// frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_mode_q   <= 1'b0;
			off_q       <= '0;
			sub_q       <= '0;
			shifter_q   <= '0;
			drive_low_q <= 1'b0;
			tx_bit_q    <= 1'b0;
			rx_full_q   <= 1'b0;
			tx_full_q   <= 1'b0;
		end else if (accept) begin
			tx_mode_q   <= tx_mode_nx;
			off_q       <= off_nx;
			sub_q       <= sub_nx;
			shifter_q   <= shifter_nx;
			drive_low_q <= drive_low_nx;
			tx_bit_q    <= tx_bit_nx;
			rx_full_q   <= rx_full_nx;
			tx_full_q   <= tx_full_nx;
		end
	end

	// word buffers
	always_ff @(posedge clk) begin
		if (accept) begin
			rx_buf_q <= rx_buf_nx;
			tx_buf_q <= tx_buf_nx;
		end
	end

	// output and skid valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid_q || !out_stall) begin
			res_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output and skid payloads
	always_ff @(posedge clk) begin
		if (!res_valid_q || !out_stall) begin
			res_q <= skid_valid_q ? skid_q : res_nx;
		end else if (accept) begin
			skid_q <= res_nx;
		end
	end

	assign out_valid      = res_valid_q;
	assign line_drive_low = res_q.line_drive_low;
	assign read_word      = res_q.read_word;
	assign read_valid     = res_q.read_valid;
	assign write_accepted = res_q.write_accepted;
	assign tx_pending     = res_q.tx_pending;
	assign rx_full        = res_q.rx_full;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid register full while output register empty");

	a_off_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_mode_q && off_q <= OFF_TX_END) || (!tx_mode_q && off_q <= OFF_RX_STOP))
		else $error("frame offset out of range");

	a_sub_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q <= SUB_LAST)
		else $error("bit tick counter out of range");

	a_read_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && read_valid) |-> (!rx_full && !write_accepted))
		else $error("read result with receive buffer still full");

	a_write_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_accepted) |-> tx_pending)
		else $error("accepted write without pending transmit word");
`endif

endmodule
`default_nettype wire
